// File: rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by every module of the block.

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int FIELD_W   = 32;

    // Operands are wrapped to the word width when it is narrower than the field
    localparam int OP_W   = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
    localparam int DVD_W  = OP_W + FRAC_BITS;
    localparam int MAX1_W = (2 * OP_W > DVD_W) ? 2 * OP_W : DVD_W;
    localparam int MAX2_W = (MAX1_W > WORD_BITS) ? MAX1_W : WORD_BITS;
    localparam int CALC_W = MAX2_W + 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_INT2FIX  = 4'd14,
        OP_FIX2INT  = 4'd15
    } t_fpa_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_fpa_status;

    typedef enum logic [1:0] {
        KIND_ALU = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2
    } t_fpa_kind;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_fpa_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic [1:0]         status;
    } t_fpa_out;

    // Classified operation as held in the queue
    typedef struct packed {
        t_fpa_op                op;
        t_fpa_kind              kind;
        logic                   neg;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
        logic [OP_W-1:0]        mag_a;
        logic [OP_W-1:0]        mag_b;
    } t_fpa_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fpa_qstat;

endpackage

// File: rtl/fixed_point_q24_8_alu_unit.sv
// Top level of the Q24.8 fixed-point ALU: front end, queue and back end.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_stall   i_in_data  (t_fpa_in)
//   out       output     o_out_valid / i_out_stall o_out_data (t_fpa_out)
//
// One operation per cycle sustained while the back end is not frozen; every
// opcode runs through the same pipeline, sized for Q24.8 by the divider pipe,
// one quotient bit per stage. Results leave in order.
// Reset is synchronous and clears all valid state; no clearing pass.
// An output stall while a result is held freezes the back end; the 4-entry queue lets the front
// keep taking transfers until it fills, then o_in_stall rises.

module fixed_point_q24_8_alu_unit
    import fpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_fpa_in  i_in_data,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_fpa_out o_out_data,
    input  logic     i_out_stall
);

    logic       q_push;
    logic       q_pop;
    t_fpa_task  q_task;
    t_fpa_task  q_head;
    t_fpa_qstat q_stat;

    fpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_task     (q_task)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (q_task),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    fpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_qstat     (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_DIVZ)
        |-> (o_out_data.result_value == '0 && !o_out_data.compare_true))
        else $error("divide by zero result not cleared");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.compare_true)
        |-> (o_out_data.status == ST_OK && o_out_data.result_value == '0))
        else $error("comparison result carries a value or status");

endmodule

// File: rtl/fpa_front.sv
// Front end: takes input transfers, wraps operands and classifies the operation.
// Depends on fpa_pkg; feeds fpa_queue.

module fpa_front
    import fpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_fpa_in    i_in_data,
    output logic       o_in_stall,
    input  t_fpa_qstat i_qstat,
    output logic       o_push,
    output t_fpa_task  o_task
);

    logic      r_vld;
    t_fpa_task r_task;
    t_fpa_task n_task;

    logic signed [OP_W-1:0] a_w;
    logic signed [OP_W-1:0] b_w;

    always_comb begin
        a_w = OP_W'(i_in_data.operand_a);
        b_w = OP_W'(i_in_data.operand_b);
        n_task.op    = t_fpa_op'(i_in_data.opcode);
        n_task.a     = a_w;
        n_task.b     = b_w;
        n_task.neg   = a_w[OP_W-1] ^ b_w[OP_W-1];
        // magnitude of the most negative value still fits unsigned
        n_task.mag_a = a_w[OP_W-1] ? OP_W'(-a_w) : OP_W'(a_w);
        n_task.mag_b = b_w[OP_W-1] ? OP_W'(-b_w) : OP_W'(b_w);
        if (n_task.op == OP_MUL) begin
            n_task.kind = KIND_MUL;
        end else if (n_task.op == OP_DIV && b_w != '0) begin
            n_task.kind = KIND_DIV;
        end else begin
            n_task.kind = KIND_ALU;
        end
    end

    assign o_push     = r_vld && !i_qstat.full;
    assign o_in_stall = r_vld && i_qstat.full;
    assign o_task     = r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_vld <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_task <= n_task;
        end
    end

endmodule

// File: rtl/fpa_queue.sv
// Short queue between the classifying front end and the execution back end.
// Depends on fpa_pkg.

module fpa_queue
    import fpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_fpa_task  i_task,
    input  logic       i_pop,
    output t_fpa_task  o_head,
    output t_fpa_qstat o_qstat
);

    t_fpa_task       r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
    end

endmodule

// File: rtl/fpa_back.sv
// Back end: operand stage, one restoring divide step per stage, then sign,
// saturation and the output register. Depends on fpa_pkg; fed by fpa_queue.

module fpa_back
    import fpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fpa_task  i_head,
    input  t_fpa_qstat i_qstat,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_fpa_out   o_out_data,
    input  logic       i_out_stall
);

    typedef struct packed {
        t_fpa_kind                kind;
        logic                     neg;
        logic [OP_W-1:0]          rem;
        logic [DVD_W-1:0]         dq;
        logic [OP_W-1:0]          dvsr;
        logic signed [CALC_W-1:0] res;
        logic                     cmp;
        logic [1:0]               status;
    } t_fpa_work;

    localparam logic signed [CALC_W-1:0] SAT_HI =
        {{(CALC_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [CALC_W-1:0] SAT_LO = ~SAT_HI;

    t_fpa_work r_w   [0:DVD_W];
    logic      r_vld [0:DVD_W];
    t_fpa_work n_w0;
    t_fpa_work n_w   [1:DVD_W];
    logic      r_out_vld;
    t_fpa_out  r_out;
    t_fpa_out  n_out;
    logic      adv;

    logic signed [CALC_W-1:0] ea;
    logic signed [CALC_W-1:0] eb;
    logic [2*OP_W-1:0]        prod;
    logic [OP_W:0]            shifted [1:DVD_W];
    logic                     ge      [1:DVD_W];
    logic signed [CALC_W-1:0] mag;
    logic signed [CALC_W-1:0] fin;
    logic                     ovf;

    assign adv   = !(r_out_vld && i_out_stall);
    assign o_pop = adv && !i_qstat.empty;

    // operand stage
    always_comb begin
        ea   = CALC_W'(i_head.a);
        eb   = CALC_W'(i_head.b);
        prod = i_head.mag_a * i_head.mag_b;
        n_w0        = '0;
        n_w0.kind   = i_head.kind;
        n_w0.neg    = i_head.neg;
        n_w0.status = ST_OK;
        unique case (i_head.kind)
            KIND_MUL: begin
                n_w0.res = signed'(CALC_W'(prod));
            end
            KIND_DIV: begin
                n_w0.dq   = {i_head.mag_a, {FRAC_BITS{1'b0}}};
                n_w0.dvsr = i_head.mag_b;
            end
            default: begin
                unique case (i_head.op)
                    OP_ADD:     n_w0.res = ea + eb;
                    OP_SUB:     n_w0.res = ea - eb;
                    OP_MUL:     n_w0.res = '0;
                    OP_DIV:     n_w0.status = ST_DIVZ;  // only zero divisors land here
                    OP_GT:      n_w0.cmp = (i_head.a > i_head.b);
                    OP_LT:      n_w0.cmp = (i_head.a < i_head.b);
                    OP_GE:      n_w0.cmp = (i_head.a >= i_head.b);
                    OP_LE:      n_w0.cmp = (i_head.a <= i_head.b);
                    OP_EQ:      n_w0.cmp = (i_head.a == i_head.b);
                    OP_NE:      n_w0.cmp = (i_head.a != i_head.b);
                    OP_MIN:     n_w0.res = (i_head.a <= i_head.b) ? ea : eb;
                    OP_MAX:     n_w0.res = (i_head.a >= i_head.b) ? ea : eb;
                    OP_INC:     n_w0.res = ea + CALC_W'(1);
                    OP_DEC:     n_w0.res = ea - CALC_W'(1);
                    OP_INT2FIX: n_w0.res = ea <<< FRAC_BITS;
                    OP_FIX2INT: n_w0.res = CALC_W'(i_head.a >>> FRAC_BITS);
                endcase
            end
        endcase
    end

    // divide steps: non-divide items ride through untouched
    always_comb begin
        for (int k = 1; k <= DVD_W; k++) begin
            n_w[k]     = r_w[k-1];
            shifted[k] = {r_w[k-1].rem, r_w[k-1].dq[DVD_W-1]};
            ge[k]      = (shifted[k] >= {1'b0, r_w[k-1].dvsr});
            if (r_w[k-1].kind == KIND_DIV) begin
                n_w[k].rem = ge[k] ? OP_W'(shifted[k] - {1'b0, r_w[k-1].dvsr})
                                   : OP_W'(shifted[k]);
                n_w[k].dq  = {r_w[k-1].dq[DVD_W-2:0], ge[k]};
            end
        end
    end

    // sign, saturation, output format
    always_comb begin
        mag = '0;
        unique case (r_w[DVD_W].kind)
            KIND_MUL: begin
                mag = r_w[DVD_W].res >>> FRAC_BITS;
                fin = r_w[DVD_W].neg ? -mag : mag;
            end
            KIND_DIV: begin
                mag = signed'(CALC_W'(r_w[DVD_W].dq));
                fin = r_w[DVD_W].neg ? -mag : mag;
            end
            default: begin
                fin = r_w[DVD_W].res;
            end
        endcase
        ovf = (fin > SAT_HI) || (fin < SAT_LO);
        n_out.compare_true = r_w[DVD_W].cmp;
        if (fin > SAT_HI) begin
            n_out.result_value = 32'(SAT_HI);
        end else if (fin < SAT_LO) begin
            n_out.result_value = 32'(SAT_LO);
        end else begin
            n_out.result_value = 32'(fin);
        end
        n_out.status = ovf ? ST_OVF : r_w[DVD_W].status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DVD_W; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= o_pop;
            for (int k = 1; k <= DVD_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[DVD_W];
        end
        if (adv) begin
            r_w[0] <= n_w0;
            for (int k = 1; k <= DVD_W; k++) begin
                r_w[k] <= n_w[k];
            end
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
